[hw/rtl/lfdgf_pkg.sv]
// Shared types, constants and lookup functions for the LED frame flush core.
// Depends on nothing; the controller, datapath and top level import it.
package lfdgf_pkg;

    localparam int LED_COUNT   = 43;
    localparam int ROW_AW      = 6;
    localparam int GROUP_COUNT = 12;

    localparam logic [7:0] PAGE_SELECT_REG = 8'hFD;
    localparam logic [7:0] GROUP_BASE      = 8'h20;
    localparam logic [6:0] DEV_ADDR_RESET  = 7'd116;
    localparam logic [4:0] PSEL_BYTES      = 5'd1;
    localparam logic [4:0] GROUP_BYTES     = 5'd16;

    typedef enum logic [1:0] {
        ACT_PSEL  = 2'd0,
        ACT_GROUP = 2'd1,
        ACT_STOP  = 2'd2
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_COL_WR,
        ST_PAGE,
        ST_SCAN,
        ST_GATHER,
        ST_EMIT
    } state_t;

    // slot map per band: 0 is a fixed zero slot, otherwise LED number + 1
    localparam logic [5:0] BAND_MAP [4][16] = '{
        '{6'd0,  6'd0,  6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
          6'd6,  6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13},
        '{6'd14, 6'd15, 6'd16, 6'd0,  6'd0,  6'd0,  6'd17, 6'd18,
          6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26},
        '{6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd0,  6'd0,
          6'd0,  6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39},
        '{6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
          6'd40, 6'd0,  6'd0,  6'd0,  6'd41, 6'd42, 6'd43, 6'd0}
    };

    typedef struct packed {
        logic       cap;
        logic       rd_col;
        logic       wr_col;
        logic       rd_slot;
        logic       shift;
        logic       emit;
        act_t       act;
        logic       hdr;
        logic       page;
        logic [3:0] grp;
        logic [3:0] slot;
    } dp_cmd_t;

    typedef struct packed {
        logic [GROUP_COUNT-1:0] dirty;
        logic                   out_free;
        logic                   flush;
        logic                   idx_ok;
    } dp_status_t;

    function automatic logic [1:0] grp_band(input logic [3:0] g);
        logic [1:0] b;
        case (g)
            4'd0, 4'd1, 4'd2:  b = 2'd0;
            4'd3, 4'd4, 4'd5:  b = 2'd1;
            4'd6, 4'd7, 4'd8:  b = 2'd2;
            default:           b = 2'd3;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] grp_chan(input logic [3:0] g);
        logic [1:0] c;
        case (g)
            4'd0, 4'd3, 4'd6, 4'd9:  c = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10: c = 2'd1;
            default:                 c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] led_band(input logic [5:0] idx);
        logic [1:0] b;
        if (idx < 6'd13)
            b = 2'd0;
        else if (idx < 6'd26)
            b = 2'd1;
        else if (idx < 6'd39)
            b = 2'd2;
        else
            b = 2'd3;
        return b;
    endfunction

endpackage

[hw/rtl/lfdgf_in_if.sv]
// Input channel: one command word with valid/ready handshake.
// Depends on nothing.
interface lfdgf_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [5:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, command, led_index, red, green, blue, input ready);
    modport sink   (input valid, command, led_index, red, green, blue, output ready);
endinterface

[hw/rtl/lfdgf_out_if.sv]
// Output channel: one bus transfer word with valid/ready handshake.
// Depends on nothing.
interface lfdgf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic        with_header;
    logic [7:0]  register_address;
    logic [4:0]  byte_count;
    logic [63:0] data_first_half;
    logic [63:0] data_second_half;
    logic        last;

    modport source (output valid, action, with_header, register_address, byte_count,
                    data_first_half, data_second_half, last, input ready);
    modport sink   (input valid, action, with_header, register_address, byte_count,
                    data_first_half, data_second_half, last, output ready);
endinterface

[hw/rtl/lfdgf_ctrl.sv]
// Controller: sequences colour updates and the page/group flush walk.
// Depends on lfdgf_pkg.
module lfdgf_ctrl
    import lfdgf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [3:0] grp_reg, grp_next;
    logic       page_reg, page_next;
    logic       open_reg, open_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       page_dirty;
    logic       page_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            grp_reg   <= '0;
            page_reg  <= 1'b0;
            open_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            grp_reg   <= grp_next;
            page_reg  <= page_next;
            open_reg  <= open_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign page_dirty = page_reg ? (st.dirty[11:8] != 4'd0) : (st.dirty[7:0] != 8'd0);
    assign page_end   = page_reg ? (grp_reg == 4'd12) : (grp_reg == 4'd8);

    always_comb
    begin
        state_next = state_reg;
        grp_next   = grp_reg;
        page_next  = page_reg;
        open_next  = open_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.act    = ACT_STOP;
        cmd.grp    = grp_reg;
        cmd.page   = page_reg;
        cmd.slot   = cnt_reg[3:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (st.flush)
                begin
                    page_next  = 1'b0;
                    state_next = ST_PAGE;
                end
                else if (st.idx_ok)
                begin
                    cmd.rd_col = 1'b1;
                    state_next = ST_COL_WR;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_COL_WR:
            begin
                cmd.wr_col = 1'b1;
                state_next = ST_IDLE;
            end
            ST_PAGE:
            begin
                if (!page_dirty)
                begin
                    if (page_reg)
                        state_next = ST_IDLE;
                    else
                        page_next = 1'b1;
                end
                else if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.act    = ACT_PSEL;
                    grp_next   = page_reg ? 4'd8 : 4'd0;
                    open_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (page_end)
                begin
                    if (open_reg)
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit  = 1'b1;
                            open_next = 1'b0;
                        end
                    end
                    else if (page_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        page_next  = 1'b1;
                        state_next = ST_PAGE;
                    end
                end
                else if (st.dirty[grp_reg])
                begin
                    cnt_next   = '0;
                    state_next = ST_GATHER;
                end
                else if (open_reg)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit  = 1'b1;
                        open_next = 1'b0;
                        grp_next  = grp_reg + 4'd1;
                    end
                end
                else
                    grp_next = grp_reg + 4'd1;
            end
            ST_GATHER:
            begin
                // read one slot a cycle, shift in the byte read the cycle before
                cmd.rd_slot = !cnt_reg[4];
                cmd.shift   = (cnt_reg != 5'd0);
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg[4])
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.act    = ACT_GROUP;
                    cmd.hdr    = !open_reg;
                    open_next  = 1'b1;
                    grp_next   = grp_reg + 4'd1;
                    state_next = ST_SCAN;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

[hw/rtl/lfdgf_dp.sv]
// Datapath: colour store, dirty marks, group gather register and result register.
// Depends on lfdgf_pkg.
module lfdgf_dp
    import lfdgf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  st,
    input  logic        command,
    input  logic [5:0]  led_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    output logic [6:0]  device_address,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [1:0]  action,
    output logic        with_header,
    output logic [7:0]  register_address,
    output logic [4:0]  byte_count,
    output logic [63:0] data_first_half,
    output logic [63:0] data_second_half,
    output logic        last
);

    logic [23:0]            mem [LED_COUNT];
    logic [LED_COUNT-1:0]   row_valid_reg;
    logic [GROUP_COUNT-1:0] dirty_reg, dirty_next, dirty_set, dirty_clr;
    logic [6:0]             dev_addr_reg;
    logic                   flush_reg;
    logic [5:0]             idx_reg;
    logic [23:0]            rgb_reg;
    logic [23:0]            rd_data_reg;
    logic                   rd_ok_reg;
    logic [127:0]           gath_reg;
    logic                   out_valid_reg;
    act_t                   act_reg;
    logic                   hdr_reg, last_reg;
    logic [7:0]             reg_addr_reg;
    logic [4:0]             count_reg;
    logic [63:0]            d0_reg, d1_reg;

    logic [5:0]  slot_map;
    logic [ROW_AW-1:0] rd_addr;
    logic        rd_ok_next;
    logic [23:0] old_row;
    logic [7:0]  chan_byte;
    logic [3:0]  grp_base;
    logic        do_rd;

    assign slot_map = BAND_MAP[grp_band(cmd.grp)][cmd.slot];
    assign do_rd    = cmd.rd_col || cmd.rd_slot;

    always_comb
    begin
        if (cmd.rd_col)
        begin
            rd_addr    = idx_reg;
            rd_ok_next = row_valid_reg[idx_reg];
        end
        else if (slot_map != 6'd0)
        begin
            rd_addr    = slot_map - 6'd1;
            rd_ok_next = row_valid_reg[slot_map - 6'd1];
        end
        else
        begin
            rd_addr    = '0;
            rd_ok_next = 1'b0;
        end
    end

    assign old_row = rd_ok_reg ? rd_data_reg : 24'd0;

    always_comb
    begin
        case (grp_chan(cmd.grp))
            2'd0:    chan_byte = old_row[23:16];
            2'd1:    chan_byte = old_row[15:8];
            default: chan_byte = old_row[7:0];
        endcase
    end

    // mark the group of each channel whose byte changes
    assign grp_base = {led_band(idx_reg), 1'b0} + {2'b00, led_band(idx_reg)};

    always_comb
    begin
        dirty_set = '0;
        dirty_clr = '0;
        if (cmd.wr_col)
        begin
            if (old_row[23:16] != rgb_reg[23:16])
                dirty_set[grp_base] = 1'b1;
            if (old_row[15:8] != rgb_reg[15:8])
                dirty_set[grp_base + 4'd1] = 1'b1;
            if (old_row[7:0] != rgb_reg[7:0])
                dirty_set[grp_base + 4'd2] = 1'b1;
        end
        if (cmd.emit && cmd.act == ACT_GROUP)
            dirty_clr[cmd.grp] = 1'b1;
        dirty_next = (dirty_reg | dirty_set) & ~dirty_clr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_col)
            mem[idx_reg] <= rgb_reg;
        if (do_rd)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_ok_reg   <= rd_ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            dirty_reg     <= '0;
            dev_addr_reg  <= DEV_ADDR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dirty_reg <= dirty_next;
            if (cmd.wr_col)
                row_valid_reg[idx_reg] <= 1'b1;
            if (cfg_we)
                dev_addr_reg <= cfg_wdata;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            flush_reg <= command;
            idx_reg   <= led_index;
            rgb_reg   <= {red, green, blue};
        end
        if (cmd.shift)
            gath_reg <= {gath_reg[119:0], chan_byte};
        if (cmd.emit)
        begin
            act_reg <= cmd.act;
            case (cmd.act)
                ACT_PSEL:
                begin
                    hdr_reg      <= 1'b1;
                    reg_addr_reg <= PAGE_SELECT_REG;
                    count_reg    <= PSEL_BYTES;
                    d0_reg       <= {7'd0, cmd.page, 56'd0};
                    d1_reg       <= '0;
                    last_reg     <= 1'b0;
                end
                ACT_GROUP:
                begin
                    hdr_reg      <= cmd.hdr;
                    reg_addr_reg <= GROUP_BASE + {1'b0, cmd.grp[2:0], 4'd0};
                    count_reg    <= GROUP_BYTES;
                    d0_reg       <= gath_reg[127:64];
                    d1_reg       <= gath_reg[63:0];
                    last_reg     <= 1'b0;
                end
                default:
                begin
                    hdr_reg      <= 1'b0;
                    reg_addr_reg <= '0;
                    count_reg    <= '0;
                    d0_reg       <= '0;
                    d1_reg       <= '0;
                    // final stop: nothing left to send
                    last_reg     <= (dirty_reg == '0);
                end
            endcase
        end
    end

    assign st.dirty    = dirty_reg;
    assign st.out_free = !out_valid_reg || out_ready;
    assign st.flush    = flush_reg;
    assign st.idx_ok   = (idx_reg < 6'(LED_COUNT));

    assign device_address   = dev_addr_reg;
    assign out_valid        = out_valid_reg;
    assign action           = act_reg;
    assign with_header      = hdr_reg;
    assign register_address = reg_addr_reg;
    assign byte_count       = count_reg;
    assign data_first_half  = d0_reg;
    assign data_second_half = d1_reg;
    assign last             = last_reg;

`ifndef SYNTH
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");
    a_group_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.act == ACT_GROUP) |=> !dirty_reg[$past(cmd.grp)])
        else $error("sent group still marked dirty");
    a_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_col |=> row_valid_reg[$past(idx_reg)])
        else $error("written row not marked valid");
`endif

endmodule

[hw/rtl/led_frame_dirty_group_flush_core.sv]
// Top level of the LED frame dirty-group flush core.
// Depends on lfdgf_pkg, lfdgf_in_if, lfdgf_out_if, lfdgf_ctrl and lfdgf_dp.
//
// The core keeps the red, green and blue bytes of 43 LEDs and a dirty mark
// for each of twelve driver groups. A set-colour word passes through
// capture, row read, and compare and write, and produces no result; LED
// indexes above 42 are dropped. A flush word walks page 0 (groups 0-7)
// and then page 1 (groups 8-11): a dirty page opens with a page-select
// word, each dirty group is gathered from the colour store one slot per
// cycle through its single read port and sent as a 16-byte word, adjacent
// dirty groups share one header and every run ends with one stop. A flush
// is held up while the sink stalls. The final word of a flush carries
// last. The colour store resets to zero through per-row valid flags, so no
// clearing pass is needed. The device address register is held for the
// bus layer and does not enter any result word. The result register lets
// a new input word be taken while the last result of a flush still waits.
module led_frame_dirty_group_flush_core
    import lfdgf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lfdgf_in_if.sink    request,
    lfdgf_out_if.source result,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t st;
    logic [6:0] device_address;

    // controller: state machine, group and page counters
    lfdgf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: colour store, dirty marks, gather and result registers
    lfdgf_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .command          (request.command),
        .led_index        (request.led_index),
        .red              (request.red),
        .green            (request.green),
        .blue             (request.blue),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .device_address   (device_address),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .action           (result.action),
        .with_header      (result.with_header),
        .register_address (result.register_address),
        .byte_count       (result.byte_count),
        .data_first_half  (result.data_first_half),
        .data_second_half (result.data_second_half),
        .last             (result.last)
    );

`ifndef SYNTH
    a_addr_held: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cfg_we) |-> $stable(device_address))
        else $error("device address changed without a write");
`endif

endmodule

[dv/lfdgf_tb_pkg.sv]
`timescale 1ns / 1ps
// Stimulus word and expected bus-word types for the flush core testbench.
// Depends on lfdgf_pkg.
package lfdgf_tb_pkg;
    import lfdgf_pkg::*;

    typedef struct packed {
        logic       command;
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cmd_word_t;

    typedef struct packed {
        act_t        action;
        logic        with_header;
        logic [7:0]  register_address;
        logic [4:0]  byte_count;
        logic [63:0] data_first_half;
        logic [63:0] data_second_half;
        logic        last;
    } bus_word_t;

    localparam logic CMD_SET   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;
endpackage

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for led_frame_dirty_group_flush_core.
// Depends on lfdgf_pkg, lfdgf_tb_pkg, the two channel interfaces and the core.
module testbench;
    import lfdgf_pkg::*;
    import lfdgf_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [6:0] cfg_wdata;

    lfdgf_in_if  request ();
    lfdgf_out_if result ();

    led_frame_dirty_group_flush_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the block's state: colour bytes, dirty marks, address.
    logic [7:0]  shadow_colour [LED_COUNT*3];
    logic [11:0] shadow_dirty;
    logic [6:0]  shadow_dev_addr;

    bus_word_t pending_words [$];
    int        error_count;
    int        idle_cycles;
    bit        stim_done;

    // Slot map per band, held locally: 0 is a fixed zero slot, else LED + 1.
    int slot_led [4][16] = '{
        '{0, 0, 0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13},
        '{14, 15, 16, 0, 0, 0, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26},
        '{27, 28, 29, 30, 31, 32, 0, 0, 0, 33, 34, 35, 36, 37, 38, 39},
        '{0, 0, 0, 0, 0, 0, 0, 0, 40, 0, 0, 0, 41, 42, 43, 0}
    };

    function automatic bus_word_t make_word(act_t a, logic h, logic [7:0] r,
                                            logic [4:0] n, logic [63:0] d0,
                                            logic [63:0] d1);
        bus_word_t w;
        w.action           = a;
        w.with_header      = h;
        w.register_address = r;
        w.byte_count       = n;
        w.data_first_half  = d0;
        w.data_second_half = d1;
        w.last             = 1'b0;
        return w;
    endfunction

    // Gather the 16 bytes of one group from the shadow store.
    function automatic bus_word_t group_word(int g, logic h);
        logic [127:0] bytes;
        int m;
        bytes = '0;
        for (int i = 0; i < 16; i++)
        begin
            m = slot_led[g / 3][i];
            if (m != 0)
                bytes[(15 - i) * 8 +: 8] = shadow_colour[(m - 1) * 3 + g % 3];
        end
        return make_word(ACT_GROUP, h, GROUP_BASE + 8'(16 * (g % 8)), GROUP_BYTES,
                         bytes[127:64], bytes[63:0]);
    endfunction

    // Walk one page of groups, queueing the bus words a flush produces.
    task automatic queue_page(int page, int first, int count, inout int produced);
        bit run_open;
        run_open = 0;
        if ((shadow_dirty & (((12'd1 << count) - 1) << first)) == 0)
            return;
        pending_words.push_back(make_word(ACT_PSEL, 1'b1, PAGE_SELECT_REG, PSEL_BYTES,
                                          64'(page) << 56, 64'd0));
        produced++;
        for (int g = first; g < first + count; g++)
        begin
            if (shadow_dirty[g])
            begin
                pending_words.push_back(group_word(g, !run_open));
                produced++;
                run_open = 1;
                shadow_dirty[g] = 1'b0;
            end
            else if (run_open)
            begin
                pending_words.push_back(make_word(ACT_STOP, 1'b0, 8'd0, 5'd0, 0, 0));
                produced++;
                run_open = 0;
            end
        end
        if (run_open)
        begin
            pending_words.push_back(make_word(ACT_STOP, 1'b0, 8'd0, 5'd0, 0, 0));
            produced++;
        end
    endtask

    // Apply one accepted command word to the shadow state.
    task automatic predict_command(cmd_word_t c);
        int produced;
        bus_word_t tail;
        produced = 0;
        if (c.command == CMD_SET)
        begin
            if (c.led_index < LED_COUNT)
                for (int ch = 0; ch < 3; ch++)
                begin
                    logic [7:0] v;
                    v = (ch == 0) ? c.red : (ch == 1) ? c.green : c.blue;
                    if (shadow_colour[c.led_index * 3 + ch] != v)
                    begin
                        shadow_colour[c.led_index * 3 + ch] = v;
                        shadow_dirty[(c.led_index / 13) * 3 + ch] = 1'b1;
                    end
                end
        end
        else
        begin
            queue_page(0, 0, 8, produced);
            queue_page(1, 8, 4, produced);
            if (produced > 0)
            begin
                tail = pending_words.pop_back();
                tail.last = 1'b1;
                pending_words.push_back(tail);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sink side: random stall per word, compare each word on acceptance.
    initial
    begin
        int stall;
        bus_word_t got, want;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 4);
            if (stall != 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
            got = make_word(act_t'(result.action), result.with_header,
                            result.register_address, result.byte_count,
                            result.data_first_half, result.data_second_half);
            got.last = result.last;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $realtime, got);
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                begin
                    $display("%0t: word mismatch expected %h actual %h",
                             $realtime, want, got);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if ((request.valid && request.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (rst_n);
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Send one command word, holding valid until accepted, then idle for a random gap that may be zero.
    task automatic send_word(cmd_word_t c);
        int gap;
        request.valid     <= 1'b1;
        request.command   <= c.command;
        request.led_index <= c.led_index;
        request.red       <= c.red;
        request.green     <= c.green;
        request.blue      <= c.blue;
        @(posedge clk);
        while (!request.ready)
            @(posedge clk);
        predict_command(c);
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            request.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write the address register once the block has drained.
    task automatic write_dev_addr(logic [6:0] a);
        request.valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_we          <= 1'b0;
        shadow_dev_addr = a;
    endtask

    function automatic cmd_word_t set_word(int idx, int r, int g, int b);
        return '{command: CMD_SET, led_index: 6'(idx), red: 8'(r), green: 8'(g),
                 blue: 8'(b)};
    endfunction

    function automatic cmd_word_t flush_word();
        return '{command: CMD_FLUSH, led_index: 6'($urandom), red: 8'($urandom),
                 green: 8'($urandom), blue: 8'($urandom)};
    endfunction

    // Directed table: extremes, out-of-range index, unchanged colour,
    // clean page, nothing dirty, adjacent and split runs, page end.
    cmd_word_t directed [] = '{
        '{CMD_FLUSH, 6'd63, 8'hFF, 8'hFF, 8'hFF},
        '{CMD_SET, 6'd0, 8'h00, 8'h00, 8'h00},
        '{CMD_SET, 6'd63, 8'hFF, 8'hFF, 8'hFF},
        '{CMD_SET, 6'd43, 8'h12, 8'h34, 8'h56},
        '{CMD_FLUSH, 6'd0, 8'h00, 8'h00, 8'h00},
        '{CMD_SET, 6'd0, 8'hFF, 8'h00, 8'h00},
        '{CMD_FLUSH, 6'd0, 8'h00, 8'h00, 8'h00},
        '{CMD_SET, 6'd42, 8'hAA, 8'h55, 8'hFF},
        '{CMD_FLUSH, 6'd0, 8'h00, 8'h00, 8'h00},
        '{CMD_SET, 6'd12, 8'h01, 8'h02, 8'h03},
        '{CMD_SET, 6'd13, 8'h80, 8'h00, 8'h7F},
        '{CMD_SET, 6'd26, 8'h00, 8'hC3, 8'h3C},
        '{CMD_SET, 6'd39, 8'hFE, 8'hEF, 8'h00},
        '{CMD_FLUSH, 6'd21, 8'h00, 8'h00, 8'h00},
        '{CMD_SET, 6'd38, 8'h11, 8'h22, 8'h33},
        '{CMD_SET, 6'd40, 8'h44, 8'h00, 8'h66},
        '{CMD_FLUSH, 6'd0, 8'h00, 8'h00, 8'h00},
        '{CMD_FLUSH, 6'd0, 8'h00, 8'h00, 8'h00}
    };

    initial
    begin
        int led;
        error_count  = 0;
        idle_cycles  = 0;
        stim_done    = 0;
        shadow_dirty = '0;
        shadow_dev_addr = DEV_ADDR_RESET;
        for (int i = 0; i < LED_COUNT * 3; i++)
            shadow_colour[i] = 8'd0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        request.valid     = 1'b0;
        request.command   = 1'b0;
        request.led_index = '0;
        request.red       = '0;
        request.green     = '0;
        request.blue      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_dev_addr(7'd0);
        // Flush after reset: the first row must give no word at all.
        foreach (directed[i])
            send_word(directed[i]);

        write_dev_addr(7'd127);
        // Random part: mostly set-colour words on any LED, with flushes mixed in and one at the end.
        for (int n = 0; n < 260; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(flush_word());
            else
            begin
                led = ($urandom_range(0, 15) == 0) ? $urandom_range(43, 63)
                                                   : $urandom_range(0, 42);
                send_word(set_word(led, $urandom, $urandom, $urandom));
            end
            if (n == 130)
                write_dev_addr(7'($urandom));
        end
        send_word(flush_word());
        write_dev_addr(DEV_ADDR_RESET);

        wait (pending_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
